// ===== design/b2da_pkg.sv =====
`timescale 1ns / 1ps

package b2da_pkg;

  // ASCII code of '0' and number base
  localparam logic [5:0] ASCII_ZERO = 6'd48;
  localparam int         RADIX      = 10;
  localparam int         BIN_W      = 32;

  // Per-cycle command broadcast to every digit cell
  typedef struct packed {
    logic clear;   // zero the digit
    logic dabble;  // add-3 correction then shift in the carry from below
    logic shift;   // take the digit of the cell below
  } b2da_cell_ctrl_t;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_TRIM = 4'b0100,
    ST_EMIT = 4'b1000
  } b2da_state_t;

  // 10**n, evaluated at elaboration only
  function automatic logic [63:0] pow10(input int n);
    logic [63:0] acc;
    acc = 64'd1;
    for (int k = 0; k < n; k++) begin
      acc = acc * 64'(RADIX);
    end
    return acc;
  endfunction

endpackage

// ===== design/binary_to_decimal_ascii.sv =====
`timescale 1ns / 1ps

// Binary to decimal ASCII converter.
// Input channel: in_value (32-bit unsigned) with in_valid / in_stall. One
// number is taken at a time; in_stall is high from acceptance until the last
// digit beat of that number has been taken.
// Output channel: one beat per decimal digit, most significant first, no
// leading zeros; out_digit_char is the ASCII code, out_last marks the least
// significant digit. Zero gives the single beat '0'. Only the DIGIT_SLOTS
// least significant digits are kept when the number has more.
// Sequence: a row of DIGIT_SLOTS BCD cells runs 32 shift-and-add-3 steps,
// then shifts out leading zeros one per cycle, then emits one digit per
// cycle while out_stall is low. out_valid rises once the leading zeros are
// gone; after the last beat is taken the block returns to idle and takes
// the next number, so the rate of numbers is set by the 32-step
// conversion, the digit shift and the return to idle.
// A stalled beat holds its payload; the chain waits until it is taken.
// Reset (synchronous, rst_n low) returns the block to idle and drops any
// number in flight.
module binary_to_decimal_ascii
  import b2da_pkg::*;
#(
  parameter int DIGIT_SLOTS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_digit_char,
  output logic        out_last
);

  localparam int          REM_W   = $clog2(DIGIT_SLOTS + 1);
  localparam int          BCNT_W  = $clog2(BIN_W);
  localparam logic [63:0] FULL_TH = pow10(DIGIT_SLOTS - 1);

  b2da_state_t       state_r, state_nxt;
  logic [BIN_W-1:0]  bin_r, bin_nxt;
  logic [BCNT_W-1:0] bcnt_r, bcnt_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic              full_r, full_nxt;
  b2da_cell_ctrl_t   ctrl;

  logic [DIGIT_SLOTS:0] carry;
  logic [3:0]           digit [DIGIT_SLOTS+1];
  logic [3:0]           top_digit;

  logic in_acc;
  logic out_acc;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

  // Digit chain: carries and digits move up by one cell
  assign carry[0] = bin_r[BIN_W-1];
  assign digit[0] = 4'd0;

  for (genvar i = 0; i < DIGIT_SLOTS; i++) begin : g_cell
    b2da_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .bit_in    (carry[i]),
      .digit_in  (digit[i]),
      .bit_out   (carry[i+1]),
      .digit_out (digit[i+1])
    );
  end

  assign top_digit      = digit[DIGIT_SLOTS];
  assign out_digit_char = ASCII_ZERO + {2'b00, top_digit};
  assign out_last       = (rem_r == REM_W'(1));

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    bin_nxt     = bin_r;
    bcnt_nxt    = bcnt_r;
    rem_nxt     = rem_r;
    full_nxt    = full_r;
    ctrl.clear  = 1'b0;
    ctrl.dabble = 1'b0;
    ctrl.shift  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ctrl.clear = 1'b1;
          bin_nxt    = in_value;
          bcnt_nxt   = '0;
          rem_nxt    = REM_W'(DIGIT_SLOTS);
          full_nxt   = ({32'd0, in_value} >= FULL_TH);
          state_nxt  = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.dabble = 1'b1;
        bin_nxt     = {bin_r[BIN_W-2:0], 1'b0};
        bcnt_nxt    = bcnt_r + BCNT_W'(1);
        if (bcnt_r == BCNT_W'(BIN_W - 1)) begin
          state_nxt = ST_TRIM;
        end
      end
      ST_TRIM: begin
        // drop leading zeros unless the number fills every cell
        if (!full_r && (rem_r > REM_W'(1)) && (top_digit == 4'd0)) begin
          ctrl.shift = 1'b1;
          rem_nxt    = rem_r - REM_W'(1);
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (rem_r == REM_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            ctrl.shift = 1'b1;
            rem_nxt    = rem_r - REM_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rem_r   <= '0;
      bcnt_r  <= '0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
      bcnt_r  <= bcnt_nxt;
      full_r  <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
  end

`ifndef SYNTHESIS
  // a beat always carries a decimal digit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (top_digit <= 4'd9))
    else $error("non-decimal digit on output");

  // the final beat of a number frees the input side
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> !in_stall)
    else $error("input still stalled after last beat");

  // an accepted number starts conversion and is not yet emitting
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && !out_valid))
    else $error("bad state after input beat");
`endif

endmodule

// ===== design/b2da_cell.sv =====
`timescale 1ns / 1ps

// One BCD digit of the conversion chain
module b2da_cell
  import b2da_pkg::*;
(
  input  logic            clk,
  input  b2da_cell_ctrl_t ctrl,
  input  logic            bit_in,     // carry from the cell below
  input  logic [3:0]      digit_in,   // digit of the cell below
  output logic            bit_out,    // carry to the cell above
  output logic [3:0]      digit_out
);

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] adj;

  // add-3 when the digit would reach ten after doubling
  assign adj     = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
  assign bit_out = adj[3];

  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clear) begin
      digit_nxt = 4'd0;
    end else if (ctrl.dabble) begin
      digit_nxt = {adj[2:0], bit_in};
    end else if (ctrl.shift) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit_out = digit_r;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import b2da_pkg::*;

  localparam int SLOTS       = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 60;

  typedef struct packed {
    logic [5:0] ch;
    logic       last;
  } digit_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_digit_char;
  logic        out_last;

  logic [31:0] pending_values[$];
  digit_beat_t expected_digits[$];
  int          sender_gap_pct = 0;
  int          receiver_stall_pct = 0;
  int          issued_count = 0;
  int          accepted_count = 0;
  int          failures = 0;
  int          cycles = 0;

  binary_to_decimal_ascii #(.DIGIT_SLOTS(SLOTS)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_digit_char(out_digit_char),
    .out_last      (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Split a number into decimal digits, least significant first, and queue
  // the beats most significant first with the last flag on the units digit.
  function automatic void predict_digits(input logic [31:0] value);
    logic [3:0]  store[SLOTS];
    logic [31:0] n;
    int          count;
    digit_beat_t beat;
    n = value;
    count = 0;
    do begin
      store[count] = 4'(n % RADIX);
      n = n / RADIX;
      count++;
    end while (n != 0 && count < SLOTS);
    for (int k = count - 1; k >= 0; k--) begin
      beat.ch   = ASCII_ZERO + 6'(store[k]);
      beat.last = (k == 0);
      expected_digits.push_back(beat);
    end
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // Sender: hold the beat until taken, then present the next or idle
  always @(negedge clk) begin
    if (!in_valid || accepted_count == issued_count) begin
      if (pending_values.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
        in_valid <= 1'b1;
        in_value <= pending_values.pop_front();
        issued_count <= issued_count + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Check digit beats, then record accepted numbers
  always @(posedge clk) begin
    digit_beat_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_digits.size() == 0) begin
          note_failure($sformatf("unexpected beat: char %0d last %0b",
                                 out_digit_char, out_last));
        end else begin
          want = expected_digits.pop_front();
          if (out_digit_char !== want.ch || out_last !== want.last) begin
            note_failure($sformatf("digit mismatch: expected char %0d last %0b, got char %0d last %0b",
                                   want.ch, want.last, out_digit_char, out_last));
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_digits(in_value);
        accepted_count <= accepted_count + 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Wait until every queued number is taken and all its digits are out
  task automatic wait_drained();
    while (pending_values.size() > 0 || in_valid || expected_digits.size() > 0) begin
      @(negedge clk);
    end
  endtask

  // Random numbers spread over all digit lengths, zero and decade edges
  task automatic feed_phase(input int gap_pct, input int stall_pct, input int count);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [31:0] v;
    int          d;
    sender_gap_pct = gap_pct;
    receiver_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        0: v = $urandom;
        1: v = '0;
        2, 3: begin
          d = $urandom_range(1, 10);
          lo = 64'd1;
          for (int k = 1; k < d; k++) lo = lo * RADIX;
          hi = lo * RADIX - 1;
          if (d == 1) lo = 64'd0;
          if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
          v = 32'(lo + ({32'd0, $urandom} % (hi - lo + 1)));
        end
        4: begin
          d = $urandom_range(1, 9);
          lo = 64'd1;
          for (int k = 0; k < d; k++) lo = lo * RADIX;
          v = 32'(lo + $urandom_range(0, 2) - 1);
        end
        default: v = $urandom_range(0, 99);
      endcase
      pending_values.push_back(v);
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero, single digits, decade edges, all-ones, bit patterns
    sender_gap_pct = 0;
    receiver_stall_pct = 0;
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd1);
    pending_values.push_back(32'd9);
    pending_values.push_back(32'd10);
    pending_values.push_back(32'd99);
    pending_values.push_back(32'd100);
    pending_values.push_back(32'hFFFF_FFFF);
    pending_values.push_back(32'd0);
    pending_values.push_back(32'hFFFF_FFFE);
    pending_values.push_back(32'd1000000000);
    pending_values.push_back(32'd999999999);
    pending_values.push_back(32'd1000000001);
    pending_values.push_back(32'd4000000000);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(32'h5555_5555);
    pending_values.push_back(32'hAAAA_AAAA);
    pending_values.push_back(32'd12345);
    pending_values.push_back(32'd100000);
    pending_values.push_back(32'd5);
    wait_drained();

    // Random phases; each one drains fully before the next starts
    feed_phase(0, 0, 48);
    feed_phase(84, 0, 48);
    feed_phase(0, 84, 48);
    feed_phase(16, 16, 48);

    repeat (SETTLE) @(negedge clk);
    if (failures == 0 && expected_digits.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
